[rtl/core/assert_macros.svh]
// Assertion macros for the modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Same-cycle check failed.");

// Consequent must hold in the cycle after the antecedent.
`define ESD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Next-cycle check failed.");

`endif

[rtl/core/esd_pkg.sv]
// Types and constants shared by the descending exchange sort modules.
`timescale 1ns / 1ps

package esd_pkg;

	localparam int KEY_W = 8;
	localparam int TAG_W = 16;
	localparam int REC_W = KEY_W + TAG_W;

	typedef logic [2:0] step_t;

	localparam step_t ST_WAIT = 3'd0;
	localparam step_t ST_ITEST = 3'd1;
	localparam step_t ST_LOAD = 3'd2;
	localparam step_t ST_SCAN = 3'd3;
	localparam step_t ST_WBACK = 3'd4;
	localparam step_t ST_ESET = 3'd5;
	localparam step_t ST_EMIT = 3'd6;
	localparam step_t ST_CLEAR = 3'd7;

	typedef enum logic [2:0] {
		ACT_IDLE,
		ACT_RD_I,
		ACT_LD_REG,
		ACT_CMP,
		ACT_WR_I,
		ACT_RD_K,
		ACT_EMIT,
		ACT_CLR
	} act_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_LAST_ACC,
		COND_I_DONE,
		COND_J_DONE,
		COND_K_DONE
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t go_t;
		step_t go_f;
	} uword_t;

	typedef struct packed {
		logic acc_last;
		logic i_done;
		logic j_done;
		logic k_done;
	} stat_t;

endpackage

[rtl/core/esd_ram.sv]
// Record store with one write port and one registered read port.
`timescale 1ns / 1ps

module esd_ram import esd_pkg::*; #(
	parameter int AW = 5,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/esd_seq.sv]
// Microcode sequencer: control store, step counter and conditional jumps.
`timescale 1ns / 1ps

module esd_seq import esd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output act_t  act,
	output logic  busy
);

	step_t  step_q;
	uword_t uw;
	logic   cond_ok;

	always_comb begin
		case (step_q)
			ST_WAIT:  uw = '{ACT_IDLE,   COND_LAST_ACC, ST_ITEST, ST_WAIT};
			ST_ITEST: uw = '{ACT_RD_I,   COND_I_DONE,   ST_ESET,  ST_LOAD};
			ST_LOAD:  uw = '{ACT_LD_REG, COND_ALWAYS,   ST_SCAN,  ST_SCAN};
			ST_SCAN:  uw = '{ACT_CMP,    COND_J_DONE,   ST_WBACK, ST_SCAN};
			ST_WBACK: uw = '{ACT_WR_I,   COND_ALWAYS,   ST_ITEST, ST_ITEST};
			ST_ESET:  uw = '{ACT_RD_K,   COND_ALWAYS,   ST_EMIT,  ST_EMIT};
			ST_EMIT:  uw = '{ACT_EMIT,   COND_K_DONE,   ST_CLEAR, ST_EMIT};
			ST_CLEAR: uw = '{ACT_CLR,    COND_ALWAYS,   ST_WAIT,  ST_WAIT};
			default:  uw = '{ACT_CLR,    COND_ALWAYS,   ST_WAIT,  ST_WAIT};
		endcase
	end

	always_comb begin
		case (uw.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_LAST_ACC: cond_ok = stat.acc_last;
			COND_I_DONE:   cond_ok = stat.i_done;
			COND_J_DONE:   cond_ok = stat.j_done;
			COND_K_DONE:   cond_ok = stat.k_done;
			default:       cond_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= cond_ok ? uw.go_t : uw.go_f;
		end
	end

	assign act = uw.act;
	assign busy = (step_q != ST_WAIT);

endmodule

[rtl/core/exchange_sort_descending.sv]
// Top level of the descending exchange sort: datapath, record store and sequencer.
//
// Records arrive one per transfer on start/busy: a record is taken at a rising
// edge with start high and busy low. Records are stored in arrival order; up
// to DEPTH are kept per run and later ones are dropped, which sets overflowed
// on every result of that run. The record with end_of_run high closes the run.
// Loading takes a record at every such edge and busy stays low while a run
// fills. After the closing record busy rises and the sort runs in the control
// store program: per outer position it loads that entry, compares it with each
// later entry, swapping where the later key is larger, and writes it back, all
// through the single read and write port of the store. Then the kept records
// leave as results on back-to-back cycles, each marked by valid for one cycle,
// the last with final_result high, between a setup and a clearing step. The
// receiver takes every result as it comes and cannot stall the block. busy
// falls once the run is cleared, and the next run may begin. Reset empties the
// run and returns the sequencer to waiting; store contents need no clearing.
`timescale 1ns / 1ps

module exchange_sort_descending import esd_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [KEY_W-1:0] item_key,
	input  logic [TAG_W-1:0] item_tag,
	input  logic             end_of_run,
	output logic             valid,
	output logic [KEY_W-1:0] sorted_key,
	output logic [TAG_W-1:0] sorted_tag,
	output logic             final_result,
	output logic             overflowed
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	act_t             act;
	stat_t            stat;
	logic             accept;
	logic [CW-1:0]    fill_q;
	logic             drop_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    i_inc;
	logic [CW-1:0]    j_inc;
	logic [CW-1:0]    k_inc;
	logic [KEY_W-1:0] cur_key_q;
	logic [TAG_W-1:0] cur_tag_q;
	logic             room;
	logic             swap;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [REC_W-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [REC_W-1:0] rdata;
	logic [KEY_W-1:0] rd_key;
	logic [TAG_W-1:0] rd_tag;

	assign accept = start && !busy;
	assign room = (fill_q < CW'(DEPTH));
	assign i_inc = i_q + 1'b1;
	assign j_inc = j_q + 1'b1;
	assign k_inc = k_q + 1'b1;
	assign rd_key = rdata[REC_W-1:TAG_W];
	assign rd_tag = rdata[TAG_W-1:0];
	assign swap = (cur_key_q < rd_key);

	assign stat = '{
		acc_last: accept && end_of_run,
		i_done:   (i_inc >= fill_q),
		j_done:   (j_inc == fill_q),
		k_done:   (k_inc == fill_q)
	};

	always_comb begin
		we = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = {cur_key_q, cur_tag_q};
		raddr = '0;
		case (act)
			ACT_IDLE: begin
				we = accept && room;
				waddr = fill_q[AW-1:0];
				wdata = {item_key, item_tag};
			end
			ACT_RD_I: begin
				raddr = i_q[AW-1:0];
			end
			ACT_LD_REG: begin
				raddr = j_q[AW-1:0];
			end
			ACT_CMP: begin
				we = swap;
				waddr = j_q[AW-1:0];
				raddr = j_inc[AW-1:0];
			end
			ACT_WR_I: begin
				we = 1'b1;
			end
			ACT_RD_K: begin
				raddr = '0;
			end
			ACT_EMIT: begin
				raddr = k_inc[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			drop_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			case (act)
				ACT_IDLE: begin
					i_q <= '0;
					if (accept) begin
						if (room) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ACT_RD_I: begin
					j_q <= i_inc;
				end
				ACT_CMP: begin
					j_q <= j_inc;
				end
				ACT_WR_I: begin
					i_q <= i_inc;
				end
				ACT_RD_K: begin
					k_q <= '0;
				end
				ACT_EMIT: begin
					k_q <= k_inc;
				end
				ACT_CLR: begin
					fill_q <= '0;
					drop_q <= 1'b0;
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (act == ACT_LD_REG || (act == ACT_CMP && swap)) begin
			cur_key_q <= rd_key;
			cur_tag_q <= rd_tag;
		end
	end

	esd_ram #(
		.AW(AW),
		.DW(REC_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	esd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.act    (act),
		.busy   (busy)
	);

	assign valid = (act == ACT_EMIT);
	assign sorted_key = rd_key;
	assign sorted_tag = rd_tag;
	assign final_result = valid && stat.k_done;
	assign overflowed = drop_q;

`include "assert_macros.svh"

	`ESD_ASSERT_SAME(a_valid_busy, valid, busy)
	`ESD_ASSERT_NEXT(a_final_ends, valid && final_result, !valid)
	`ESD_ASSERT_NEXT(a_last_busy, accept && end_of_run, busy)
	`ESD_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= CW'(DEPTH))

endmodule

[bench/exchange_sort_descending_test.sv]
// Self-checking testbench for the descending exchange sort with a built-in run predictor.
`timescale 1ns / 1ps

module exchange_sort_descending_test import esd_pkg::*; ;

	localparam int DEPTH = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int TARGET_ITEMS = 370;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             fin;
		logic             ovf;
	} sorted_rec_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [KEY_W-1:0] item_key;
	logic [TAG_W-1:0] item_tag;
	logic             end_of_run;
	logic             valid;
	logic [KEY_W-1:0] sorted_key;
	logic [TAG_W-1:0] sorted_tag;
	logic             final_result;
	logic             overflowed;

	logic [KEY_W-1:0] run_keys [DEPTH];
	logic [TAG_W-1:0] run_tags [DEPTH];
	int               run_fill;
	bit               run_dropped;
	sorted_rec_t      pending_sorted [$];
	int               mismatch_count;
	int               items_sent;
	bit               idle_enable;
	int               stall_cycles;

	exchange_sort_descending #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item_key(item_key),
		.item_tag(item_tag),
		.end_of_run(end_of_run),
		.valid(valid),
		.sorted_key(sorted_key),
		.sorted_tag(sorted_tag),
		.final_result(final_result),
		.overflowed(overflowed)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Stores one accepted record and, when it closes the run, queues the sorted results.
	function automatic void absorb_record(input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic last);
		logic [KEY_W-1:0] k_hold;
		logic [TAG_W-1:0] t_hold;
		sorted_rec_t      rec;
		if (run_fill < DEPTH) begin
			run_keys[run_fill] = key;
			run_tags[run_fill] = tag;
			run_fill++;
		end else begin
			run_dropped = 1'b1;
		end
		if (!last)
			return;
		for (int i = 0; i + 1 < run_fill; i++) begin
			for (int j = i + 1; j < run_fill; j++) begin
				if (run_keys[i] < run_keys[j]) begin
					k_hold = run_keys[i];
					t_hold = run_tags[i];
					run_keys[i] = run_keys[j];
					run_tags[i] = run_tags[j];
					run_keys[j] = k_hold;
					run_tags[j] = t_hold;
				end
			end
		end
		for (int k = 0; k < run_fill; k++) begin
			rec.key = run_keys[k];
			rec.tag = run_tags[k];
			rec.fin = (k + 1 == run_fill);
			rec.ovf = run_dropped;
			pending_sorted.push_back(rec);
		end
		run_fill = 0;
		run_dropped = 1'b0;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
			input logic last);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item_key <= key;
		item_tag <= tag;
		end_of_run <= last;
		do @(posedge clk); while (busy);
		absorb_record(key, tag, last);
		items_sent++;
	endtask

	// Keys are often drawn from a narrow range so that runs hold equal keys.
	task automatic send_random_run(input int len);
		logic [KEY_W-1:0] key;
		for (int n = 0; n < len; n++) begin
			key = KEY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
				: $urandom_range(0, 255));
			send_record(key, TAG_W'($urandom_range(0, 65535)), n == len - 1);
		end
	endtask

	task automatic wait_drained();
		while (pending_sorted.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_single_record();
		send_record(8'd0, 16'h0000, 1'b1);
		send_record(8'd255, 16'hFFFF, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_record(8'd0, 16'h0000, 1'b0);
		send_record(8'd255, 16'hFFFF, 1'b0);
		send_record(8'd1, 16'h5555, 1'b0);
		send_record(8'd254, 16'hAAAA, 1'b0);
		send_record(8'd128, 16'h8001, 1'b1);
	endtask

	task automatic test_equal_keys();
		send_record(8'd9, 16'h0001, 1'b0);
		send_record(8'd3, 16'h0002, 1'b0);
		send_record(8'd9, 16'h0003, 1'b0);
		send_record(8'd3, 16'h0004, 1'b0);
		send_record(8'd9, 16'h0005, 1'b0);
		send_record(8'd3, 16'h0006, 1'b1);
	endtask

	task automatic test_presorted();
		send_record(8'd10, 16'h0A0A, 1'b0);
		send_record(8'd20, 16'h1414, 1'b0);
		send_record(8'd30, 16'h1E1E, 1'b0);
		send_record(8'd40, 16'h2828, 1'b1);
		send_record(8'd200, 16'hC8C8, 1'b0);
		send_record(8'd150, 16'h9696, 1'b0);
		send_record(8'd100, 16'h6464, 1'b0);
		send_record(8'd50, 16'h3232, 1'b1);
	endtask

	// A full store, a closing record that is dropped, and a run well past capacity.
	task automatic test_store_full();
		send_random_run(DEPTH);
		send_random_run(DEPTH + 1);
		send_random_run(DEPTH + 8);
	endtask

	task automatic test_drain_pause();
		send_random_run(5);
		wait_drained();
		send_random_run(3);
	endtask

	task automatic test_random_runs();
		int len;
		while (items_sent < TARGET_ITEMS - 40) begin
			idle_enable = ($urandom_range(0, 2) != 0);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 4)
				: $urandom_range(1, 8);
			send_random_run(len);
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
	endtask

	task automatic test_steady_stream();
		idle_enable = 1'b0;
		while (items_sent < TARGET_ITEMS)
			send_random_run($urandom_range(1, 6));
	endtask

	always @(posedge clk) begin
		sorted_rec_t want;
		if (arst_n && valid) begin
			if (pending_sorted.size() == 0) begin
				flag_mismatch($sformatf("unexpected result key %0d tag %h", sorted_key,
					sorted_tag));
			end else begin
				want = pending_sorted.pop_front();
				if (sorted_key !== want.key)
					flag_mismatch($sformatf("sorted_key %0d, expected %0d", sorted_key,
						want.key));
				if (sorted_tag !== want.tag)
					flag_mismatch($sformatf("sorted_tag %h, expected %h", sorted_tag,
						want.tag));
				if (final_result !== want.fin)
					flag_mismatch($sformatf("final_result %b, expected %b", final_result,
						want.fin));
				if (overflowed !== want.ovf)
					flag_mismatch($sformatf("overflowed %b, expected %b", overflowed,
						want.ovf));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[exchange_sort_descending] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item_key = '0;
		item_tag = '0;
		end_of_run = 1'b0;
		run_fill = 0;
		run_dropped = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		stall_cycles = 0;
		idle_enable = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_record();
		test_field_extremes();
		test_equal_keys();
		test_presorted();
		test_store_full();
		test_drain_pause();
		test_random_runs();
		test_steady_stream();
		start <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("[exchange_sort_descending] OK");
		else
			$display("[exchange_sort_descending] ERROR");
		$finish;
	end

endmodule
